### hdl/jbt_pkg.sv
// Package for the JSON byte tokenizer: token and bundle types, character
// codes, scan modes and position helpers. No dependencies.
`default_nettype none

package jbt_pkg;

  // Position counter saturates at this many bytes
  localparam int unsigned MAX_TEXT_BYTES = 65536;
  localparam int unsigned POS_W   = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned EXT_W   = ((POS_W > START_W) ? POS_W : START_W) + 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_BYTES);

  // Scan modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_BARE = 2'd3;

  // Token kinds
  localparam logic [2:0] KIND_STRING = 3'd0;
  localparam logic [2:0] KIND_SIGN   = 3'd1;
  localparam logic [2:0] KIND_BARE   = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef struct packed {
    logic [2:0]         kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [7:0]         sign;
  } token_t;

  // Up to three tokens caused by one byte
  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     tok;
  } bundle_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
           (c == CH_RBRACK) || (c == CH_COLON) || (c == CH_COMMA);
  endfunction

  // Clamp a position to the 16-bit start field
  function automatic logic [START_W-1:0] clamp16(input logic [POS_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    return (ve > EXT_W'(16'hFFFF)) ? {START_W{1'b1}} : ve[START_W-1:0];
  endfunction

  // Distance from a stored start to an end position, floored at zero
  function automatic logic [LEN_W-1:0] span(input logic [POS_W-1:0]   endpos,
                                            input logic [START_W-1:0] st);
    logic [EXT_W-1:0] e;
    logic [EXT_W-1:0] s;
    logic [EXT_W-1:0] d;
    e = EXT_W'(endpos);
    s = EXT_W'(st);
    d = e - s;
    if (e < s) return '0;
    else if (d > EXT_W'(17'h1FFFF)) return {LEN_W{1'b1}};
    else return d[LEN_W-1:0];
  endfunction

  function automatic token_t make_tok(input logic [2:0] kind,
                                      input logic [START_W-1:0] st,
                                      input logic [LEN_W-1:0] len,
                                      input logic [7:0] sc);
    token_t t;
    t.kind   = kind;
    t.start  = st;
    t.length = len;
    t.sign   = sc;
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/jbt_scan.sv
// Scanner: holds position, mode and open token start; classifies each
// request byte and forms the bundle of tokens it closes. Uses jbt_pkg.
`default_nettype none

module jbt_scan (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            acc,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output jbt_pkg::bundle_t     bundle
);
  import jbt_pkg::*;

  logic [POS_W-1:0]   pos;
  logic [1:0]         mode;
  logic [START_W-1:0] start;

  logic [POS_W-1:0]   pos_next;
  logic [1:0]         mode_next;
  logic [START_W-1:0] start_next;

  logic [POS_W-1:0]   nxt;
  logic [POS_W:0]     pos_inc;
  logic [1:0]         mode_mid;
  logic [START_W-1:0] start_mid;
  logic [1:0]         n;
  token_t [2:0]       tok;
  logic               blank;
  logic               sign;

  assign blank   = is_blank(data_byte);
  assign sign    = is_sign(data_byte);
  assign pos_inc = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};
  assign nxt     = (pos_inc < {1'b0, MAX_POS}) ? pos_inc[POS_W-1:0] : MAX_POS;

  // Classify the byte and collect closed tokens
  always_comb begin
    mode_mid  = mode;
    start_mid = start;
    n         = 2'd0;
    tok       = '0;
    unique case (mode)
      MODE_IDLE: begin
        if (data_byte == CH_QUOTE) begin
          start_mid = clamp16(nxt);
          mode_mid  = MODE_STR;
        end else if (sign) begin
          tok[n] = make_tok(KIND_SIGN, clamp16(pos), LEN_W'(1), data_byte);
          n      = n + 2'd1;
        end else if (!blank) begin
          start_mid = clamp16(pos);
          mode_mid  = MODE_BARE;
        end
      end
      MODE_STR: begin
        if (data_byte == CH_QUOTE) begin
          tok[n]   = make_tok(KIND_STRING, start, span(pos, start), 8'h00);
          n        = n + 2'd1;
          mode_mid = MODE_IDLE;
        end else if (data_byte == CH_BSLASH) begin
          mode_mid = MODE_ESC;
        end
      end
      MODE_ESC: begin
        mode_mid = MODE_STR;
      end
      MODE_BARE: begin
        if (blank || sign) begin
          tok[n] = make_tok(KIND_BARE, start, span(pos, start), 8'h00);
          n      = n + 2'd1;
          if (sign) begin
            tok[n] = make_tok(KIND_SIGN, clamp16(pos), LEN_W'(1), data_byte);
            n      = n + 2'd1;
          end
          mode_mid = MODE_IDLE;
        end
      end
      default: begin
        mode_mid = MODE_IDLE;
      end
    endcase

    // Close the text on the last byte
    if (last_byte) begin
      if (mode_mid == MODE_BARE) begin
        tok[n] = make_tok(KIND_BARE, start_mid, span(nxt, start_mid), 8'h00);
        n      = n + 2'd1;
        tok[n] = make_tok(KIND_END, '0, '0, 8'h00);
        n      = n + 2'd1;
      end else if (mode_mid == MODE_STR || mode_mid == MODE_ESC) begin
        tok[n] = make_tok(KIND_ERROR, start_mid, span(nxt, start_mid), 8'h00);
        n      = n + 2'd1;
      end else begin
        tok[n] = make_tok(KIND_END, '0, '0, 8'h00);
        n      = n + 2'd1;
      end
    end

    bundle.cnt = n;
    bundle.tok = tok;
  end

  // Next scan state: return to reset values after the last byte
  always_comb begin
    pos_next   = pos;
    mode_next  = mode;
    start_next = start;
    if (acc) begin
      if (last_byte) begin
        pos_next   = '0;
        mode_next  = MODE_IDLE;
        start_next = '0;
      end else begin
        pos_next   = nxt;
        mode_next  = mode_mid;
        start_next = start_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      mode  <= MODE_IDLE;
      start <= '0;
    end else begin
      pos   <= pos_next;
      mode  <= mode_next;
      start <= start_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    acc && last_byte |=> (mode == MODE_IDLE) && (pos == '0) && (start == '0))
    else $error("scan state not cleared after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    last_byte |-> bundle.cnt != 2'd0)
    else $error("last byte produced no result");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    pos <= MAX_POS)
    else $error("position beyond saturation limit");

endmodule

`default_nettype wire

### hdl/jbt_outq.sv
// Result register: holds the token bundle of one byte and hands the tokens
// out one per cycle while out_ready is high, marking the last one. Uses jbt_pkg.
`default_nettype none

module jbt_outq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire jbt_pkg::bundle_t              bundle,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output jbt_pkg::token_t                    tok_out,
  output logic                               run_end
);
  import jbt_pkg::*;

  logic [1:0]   cnt;
  logic [1:0]   idx;
  token_t [2:0] tok;

  logic [1:0]   cnt_next;
  logic [1:0]   idx_next;
  logic         take;
  logic         last_take;
  logic         load;

  assign out_valid = (cnt != 2'd0);
  assign run_end   = (idx == (cnt - 2'd1));
  assign tok_out   = tok[idx];
  assign take      = out_valid && out_ready;
  assign last_take = take && run_end;
  assign in_ready  = (cnt == 2'd0) || last_take;
  assign load      = in_valid && in_ready && (bundle.cnt != 2'd0);

  // Load a new bundle, advance, or drop the drained one
  always_comb begin
    cnt_next = cnt;
    idx_next = idx;
    if (load) begin
      cnt_next = bundle.cnt;
      idx_next = 2'd0;
    end else if (last_take) begin
      cnt_next = 2'd0;
      idx_next = 2'd0;
    end else if (take) begin
      idx_next = idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else begin
      cnt <= cnt_next;
      idx <= idx_next;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      tok <= bundle.tok;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0) |-> (idx < cnt))
    else $error("read index beyond bundle count");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    take && !last_take |=> (idx == $past(idx) + 2'd1) && (cnt == $past(cnt)))
    else $error("read index did not advance by one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> (idx == $past(idx)) && (cnt == $past(cnt)))
    else $error("bundle changed while result stalled");

endmodule

`default_nettype wire

### hdl/json_byte_tokenizer.sv
// Top level of the JSON byte tokenizer: scanner feeding a result register.
// Depends on jbt_pkg, jbt_scan and jbt_outq.
//
//   channel  direction  handshake            payload
//   input    sink       in_valid / in_ready  data_byte, last_byte
//   output   source     out_valid/out_ready  token_kind, token_offset,
//                                            token_length, sign_char, run_end
//
// One byte is taken per cycle while in_ready is high; its tokens appear the cycle after acceptance.
// A byte that closes tokens holds its bundle in the result register until
// its last token is taken; in_ready stays low until that token is taken.
// Bytes that close no token pass straight through the scanner with no
// output-side cost unless earlier tokens are still waiting.
// rst (synchronous) clears position, scan mode and the result register.
`default_nettype none

module json_byte_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       token_kind,
  output logic [15:0]      token_offset,
  output logic [16:0]      token_length,
  output logic [7:0]       sign_char,
  output logic             run_end
);
  import jbt_pkg::*;

  bundle_t bundle;
  token_t  tok_out;
  logic    acc;

  assign acc = in_valid && in_ready;

  jbt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .bundle    (bundle)
  );

  jbt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .bundle    (bundle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tok_out   (tok_out),
    .run_end   (run_end)
  );

  assign token_kind   = tok_out.kind;
  assign token_offset = tok_out.start;
  assign token_length = tok_out.length;
  assign sign_char    = tok_out.sign;

endmodule

`default_nettype wire
